### rtl/ifc_pkg.sv
// Shared types and constants for the timed inflator fill controller.
package ifc_pkg;

    localparam int FILL_W  = 13;
    localparam int Q_W     = 7;
    localparam int DIV_N_W = 20;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_UP    = 3'd1;
    localparam logic [2:0] CMD_DOWN  = 3'd2;
    localparam logic [2:0] CMD_START = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    localparam logic [1:0] MODE_SELECT   = 2'd0;
    localparam logic [1:0] MODE_PROGRESS = 2'd1;
    localparam logic [1:0] MODE_SUCCESS  = 2'd2;
    localparam logic [1:0] MODE_FINISHED = 2'd3;

    localparam logic [1:0] CFG_MAX_TARGET = 2'd0;
    localparam logic [1:0] CFG_REF_TEMP   = 2'd1;
    localparam logic [1:0] CFG_TICKS_UNIT = 2'd2;

    localparam logic [DIV_N_W-1:0] PSI_SCALE = DIV_N_W'(90);
    localparam logic [DIV_N_W-1:0] BAR_SCALE = DIV_N_W'(100);
    localparam logic [Q_W-1:0]     BAR_FULL  = Q_W'(100);

    typedef struct packed {
        logic [2:0] cmd;
        logic [9:0] pressure_adc;
        logic [7:0] temperature_deg;
    } t_in_item;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] target_psi;
        logic [6:0] pressure_psi;
        logic [6:0] bar_percent;
        logic       flat_alert;
        logic       pump_on;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [FILL_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

endpackage

### rtl/ifc_div.sv
// Shared restoring divider, one quotient bit per cycle, quotient below 2^Q_W.
module ifc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ifc_pkg::t_div_req i_req,
    output ifc_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(ifc_pkg::Q_W);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [ifc_pkg::DIV_N_W-1:0] r_rem, n_rem;
    logic [ifc_pkg::DIV_N_W-1:0] r_dv, n_dv;
    logic [ifc_pkg::Q_W-1:0]     r_q, n_q;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dv   = r_dv;
        n_q    = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_req.dividend;
            n_dv   = ifc_pkg::DIV_N_W'({i_req.divisor, {(ifc_pkg::Q_W - 1){1'b0}}});
            n_q    = '0;
        end else if (r_busy) begin
            if (r_rem >= r_dv) begin
                n_rem = r_rem - r_dv;
                n_q   = {r_q[ifc_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_q   = {r_q[ifc_pkg::Q_W-2:0], 1'b0};
            end
            n_dv  = r_dv >> 1;
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(ifc_pkg::Q_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dv  <= n_dv;
        r_q   <= n_q;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

### rtl/inflator_timed_fill_controller_core.sv
// Top level: event sequencer and fill state of the timed inflator controller.
// Key event: S_EVAL registers the result when the output is not stalled, then intake reopens.
// Tick event: pressure conversion then bar percent, both on the shared 7-step divider;
// the bar step is skipped with no fill time set, and S_EVAL then registers the result.
// Input stall is high while an item is in work; a waiting result does not block intake.
// Synchronous active-low reset restores register defaults and the select mode.
module inflator_timed_fill_controller_core #(
    parameter int ADC_BITS   = 10,
    parameter int ANIM_TICKS = 39
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ifc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ifc_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);

    localparam logic [ifc_pkg::FILL_W-1:0] ADC_FULL = ifc_pkg::FILL_W'((1 << ADC_BITS) - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PSI  = 4'b0010,
        S_BAR  = 4'b0100,
        S_EVAL = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [2:0]                 r_cmd, n_cmd;
    logic [7:0]                 r_temp_in, n_temp_in;
    logic [7:0]                 r_max_target;
    logic [7:0]                 r_ref_temp;
    logic [3:0]                 r_tpu;
    logic [1:0]                 r_mode, n_mode;
    logic [7:0]                 r_target, n_target;
    logic [6:0]                 r_pressure, n_pressure;
    logic [7:0]                 r_temp, n_temp;
    logic                       r_dropped, n_dropped;
    logic                       r_flat, n_flat;
    logic [ifc_pkg::FILL_W-1:0] r_elapsed, n_elapsed;
    logic [ifc_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [6:0]                 r_bar, n_bar;
    logic [5:0]                 r_frame, n_frame;
    logic                       r_out_valid, n_out_valid;
    ifc_pkg::t_out_item         r_out, n_out;

    ifc_pkg::t_div_req          div_req;
    ifc_pkg::t_div_rsp          div_rsp;

    logic                       in_xfer;
    logic [ifc_pkg::FILL_W-1:0] adc_ext, adc_sat;
    logic signed [9:0]          diff, half, tdiff, units;
    logic signed [14:0]         ticks;
    logic [5:0]                 frame_inc;
    logic [1:0]                 mode_w;
    logic                       flat_w;

    ifc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign adc_ext    = ifc_pkg::FILL_W'(i_in_data.pressure_adc);
    assign adc_sat    = (adc_ext > ADC_FULL) ? ADC_FULL : adc_ext;

    assign diff  = $signed({2'b00, r_target}) - $signed({3'b000, r_pressure});
    assign half  = diff >>> 1;
    assign tdiff = $signed({2'b00, r_temp}) - $signed({2'b00, r_ref_temp});
    assign units = half - tdiff;
    assign ticks = 15'(units) * $signed({11'd0, r_tpu});
    assign frame_inc = r_frame + 6'd1;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_temp_in   = r_temp_in;
        n_mode      = r_mode;
        n_target    = r_target;
        n_pressure  = r_pressure;
        n_temp      = r_temp;
        n_dropped   = r_dropped;
        n_flat      = r_flat;
        n_elapsed   = r_elapsed;
        n_fill      = r_fill;
        n_bar       = r_bar;
        n_frame     = r_frame;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mode_w      = r_mode;
        flat_w      = r_flat;
        div_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd     = i_in_data.cmd;
                    n_temp_in = i_in_data.temperature_deg;
                    if (i_in_data.cmd == ifc_pkg::CMD_TICK) begin
                        if (r_elapsed < r_fill) begin
                            n_elapsed = r_elapsed + ifc_pkg::FILL_W'(1);
                        end
                        div_req.start    = 1'b1;
                        div_req.dividend = ifc_pkg::DIV_N_W'(adc_sat) * ifc_pkg::PSI_SCALE;
                        div_req.divisor  = ADC_FULL;
                        n_state = S_PSI;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_PSI: begin
                if (div_rsp.done) begin
                    n_pressure = div_rsp.quot;
                    n_dropped  = (div_rsp.quot < r_pressure);
                    n_temp     = r_temp_in;
                    if (r_fill != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = ifc_pkg::DIV_N_W'(r_elapsed) * ifc_pkg::BAR_SCALE;
                        div_req.divisor  = r_fill;
                        n_state = S_BAR;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_BAR: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot > r_bar) begin
                        n_bar = div_rsp.quot;
                    end
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!r_out_valid || !i_out_stall) begin
                    if (r_cmd == ifc_pkg::CMD_TICK && r_mode == ifc_pkg::MODE_SUCCESS) begin
                        n_frame = frame_inc;
                        if (frame_inc >= 6'(ANIM_TICKS)) begin
                            n_frame = '0;
                            mode_w  = ifc_pkg::MODE_FINISHED;
                        end
                    end
                    n_mode = mode_w;
                    unique case (mode_w)
                        ifc_pkg::MODE_SELECT: begin
                            if (r_cmd == ifc_pkg::CMD_UP) begin
                                if (r_target < r_max_target) begin
                                    n_target = r_target + 8'd1;
                                end
                            end else if (r_cmd == ifc_pkg::CMD_DOWN) begin
                                if (r_target != 8'd0) begin
                                    n_target = r_target - 8'd1;
                                end
                            end else if (r_cmd == ifc_pkg::CMD_START) begin
                                n_elapsed = '0;
                                if (ticks[14] || ticks == '0) begin
                                    n_fill = '0;
                                    n_bar  = ifc_pkg::BAR_FULL;
                                    n_mode = ifc_pkg::MODE_FINISHED;
                                end else begin
                                    n_fill = ticks[ifc_pkg::FILL_W-1:0];
                                    n_bar  = '0;
                                    n_mode = ifc_pkg::MODE_PROGRESS;
                                end
                            end
                        end
                        ifc_pkg::MODE_PROGRESS: begin
                            flat_w = r_flat || (r_elapsed != '0 && r_dropped);
                            n_flat = flat_w;
                            if (r_cmd == ifc_pkg::CMD_STOP || r_elapsed == r_fill) begin
                                if (r_elapsed == r_fill && !flat_w) begin
                                    n_mode  = ifc_pkg::MODE_SUCCESS;
                                    n_frame = '0;
                                end else begin
                                    n_mode = ifc_pkg::MODE_FINISHED;
                                end
                                n_elapsed = '0;
                                n_fill    = '0;
                            end
                        end
                        ifc_pkg::MODE_FINISHED: begin
                            if (r_cmd == ifc_pkg::CMD_START) begin
                                n_bar  = '0;
                                n_flat = 1'b0;
                                n_mode = ifc_pkg::MODE_SELECT;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.mode         = n_mode;
                    n_out.target_psi   = n_target;
                    n_out.pressure_psi = n_pressure;
                    n_out.bar_percent  = n_bar;
                    n_out.flat_alert   = n_flat;
                    n_out.pump_on      = (n_mode == ifc_pkg::MODE_PROGRESS);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_target <= 8'd90;
            r_ref_temp   <= 8'd25;
            r_tpu        <= 4'd10;
            r_mode       <= ifc_pkg::MODE_SELECT;
            r_target     <= '0;
            r_pressure   <= '0;
            r_temp       <= '0;
            r_dropped    <= 1'b0;
            r_flat       <= 1'b0;
            r_elapsed    <= '0;
            r_fill       <= '0;
            r_bar        <= '0;
            r_frame      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_target    <= n_target;
            r_pressure  <= n_pressure;
            r_temp      <= n_temp;
            r_dropped   <= n_dropped;
            r_flat      <= n_flat;
            r_elapsed   <= n_elapsed;
            r_fill      <= n_fill;
            r_bar       <= n_bar;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ifc_pkg::CFG_MAX_TARGET: r_max_target <= i_cfg_data;
                    ifc_pkg::CFG_REF_TEMP:   r_ref_temp   <= i_cfg_data;
                    ifc_pkg::CFG_TICKS_UNIT: r_tpu        <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
        r_cmd     <= n_cmd;
        r_temp_in <= n_temp_in;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/ifc_chk.sv
// Port-level checker for the fill controller, bound to the top level.
module ifc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ifc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ifc_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_pump_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pump_on == (o_out_data.mode == ifc_pkg::MODE_PROGRESS)))
        else $error("pump drive disagrees with mode");

    a_bar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.bar_percent <= ifc_pkg::BAR_FULL))
        else $error("bar above full");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("intake open straight after a transfer");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind inflator_timed_fill_controller_core ifc_chk u_ifc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
